// ===== src/lmsa_pkg.sv =====
// Package: matrix geometry, register indexes and shared types for the sparkle animator.
package lmsa_pkg;

    localparam int COLS     = 16;
    localparam int ROWS     = 8;
    localparam int MAX_LIVE = 8;
    localparam int CELLS    = COLS * ROWS;
    localparam int NCAND    = 8;
    localparam int CW       = $clog2(CELLS);
    localparam int COLW     = $clog2(COLS);

    localparam logic [2:0] REG_MAX_LEVEL     = 3'd0;
    localparam logic [2:0] REG_SPAWN_PERCENT = 3'd1;
    localparam logic [2:0] REG_SPEED_LOW     = 3'd2;
    localparam logic [2:0] REG_SPEED_HIGH    = 3'd3;
    localparam logic [2:0] REG_LIVE_LIMIT    = 3'd4;

    typedef logic [7:0] star_word_t;

    // Store access from the sequencer to the cell store.
    typedef struct packed {
        logic       we;
        logic [CW-1:0] waddr;
        star_word_t wspeed;
        star_word_t wlevel;
        logic [CW-1:0] raddr;
    } store_req_t;

endpackage

// ===== src/lmsa_ram.sv =====
// Generic single-port-write RAM with registered read.
module lmsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/lmsa_store.sv =====
// Cell store: speed and level memories.
module lmsa_store (
    input  logic                 clk,
    input  lmsa_pkg::store_req_t req,
    output lmsa_pkg::star_word_t rspeed,
    output lmsa_pkg::star_word_t rlevel
);
    import lmsa_pkg::*;

    lmsa_ram #(.WIDTH(8), .DEPTH(CELLS)) u_speed (
        .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wspeed),
        .raddr(req.raddr), .rdata(rspeed)
    );
    lmsa_ram #(.WIDTH(8), .DEPTH(CELLS)) u_level (
        .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wlevel),
        .raddr(req.raddr), .rdata(rlevel)
    );
endmodule

// ===== src/led_matrix_sparkle_animator_top.sv =====
// Top level: sequencer walking the cell store with one shared update and neighbor unit.
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | spawn_roll, speed_offset, cand_0..cand_7
//  out     | out_valid | out_stall | kind, pixel_col, pixel_row, pixel_level, spawned,
//          |           |           |   spawn_cell, is_last
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
// After reset a clearing pass writes every cell before the first item is taken.
// One item: every cell is read and updated, live ones giving pixels up to MAX_LIVE, then
// candidates and neighbors are checked for a spawn and the end report is given.
// Each memory read port gives one word per cycle.
// Output stall holds the sequencer at its current result; input is taken only when idle.
module led_matrix_sparkle_animator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [6:0] spawn_roll,
    input  logic [6:0] speed_offset,
    input  logic [6:0] cand_0,
    input  logic [6:0] cand_1,
    input  logic [6:0] cand_2,
    input  logic [6:0] cand_3,
    input  logic [6:0] cand_4,
    input  logic [6:0] cand_5,
    input  logic [6:0] cand_6,
    input  logic [6:0] cand_7,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [3:0] pixel_col,
    output logic [2:0] pixel_row,
    output logic [7:0] pixel_level,
    output logic       spawned,
    output logic [6:0] spawn_cell,
    output logic       is_last,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import lmsa_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_CAND  = 3'd4;
    localparam logic [2:0] S_NB    = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [CW:0] idx_reg, idx_next;
    logic [3:0] cand_k_reg, cand_k_next;
    logic [3:0] nb_reg, nb_next;
    logic [3:0] active_reg, active_next;
    logic [3:0] nout_reg, nout_next;
    logic spawned_reg, spawned_next;
    logic [CW-1:0] scell_reg, scell_next;
    logic [6:0] roll_reg, off_reg;
    logic [6:0] cand_reg [NCAND];
    logic [7:0] max_level_reg;
    logic [6:0] spawn_percent_reg, speed_low_reg, speed_high_reg;
    logic [3:0] live_limit_reg;
    logic out_valid_reg, out_valid_next;
    logic kind_reg, kind_next, last_reg, last_next;
    logic [CW-1:0] ocell_reg, ocell_next;
    logic [7:0] olevel_reg, olevel_next;
    logic nb_pending_reg, nb_pending_next;

    store_req_t req;
    star_word_t rspeed, rlevel;

    lmsa_store u_store (.clk(clk), .req(req), .rspeed(rspeed), .rlevel(rlevel));

    // Shared unit: level update and neighbor address.
    logic signed [9:0] sum;
    logic [CW-1:0] cur;
    logic [6:0] cand_cur;
    logic cand_ok;
    logic signed [1:0] dr_off, dc_off;
    logic signed [7:0] nr, nc;
    logic nb_in;
    logic [7:0] spd_sum;
    logic [6:0] spd;
    logic [3:0] limit;
    logic busy_rd;

    always_comb
    begin
        unique case (nb_reg)
            4'd0, 4'd1, 4'd2: dr_off = -2'sd1;
            4'd3, 4'd4, 4'd5: dr_off = 2'sd0;
            default:          dr_off = 2'sd1;
        endcase
        unique case (nb_reg)
            4'd0, 4'd3, 4'd6: dc_off = -2'sd1;
            4'd1, 4'd4, 4'd7: dc_off = 2'sd0;
            default:          dc_off = 2'sd1;
        endcase
    end

    assign cur      = idx_reg[CW-1:0];
    assign cand_cur = cand_reg[cand_k_reg[2:0]];
    assign cand_ok  = {1'b0, cand_cur} < 8'(CELLS);
    assign sum      = 10'(signed'(rspeed)) + signed'(10'(rlevel));
    assign nr = signed'(8'(cand_cur[CW-1:COLW])) + 8'(dr_off);
    assign nc = signed'(8'(cand_cur[COLW-1:0])) + 8'(dc_off);
    assign nb_in = (nr >= 0) && (nr < 8'(ROWS)) && (nc >= 0) && (nc < 8'(COLS));
    assign spd_sum = 8'(speed_low_reg) + 8'(off_reg);
    assign spd = (spd_sum > 8'(speed_high_reg)) ? speed_high_reg : spd_sum[6:0];
    assign limit = (live_limit_reg < 4'(MAX_LIVE)) ? live_limit_reg : 4'(MAX_LIVE);
    assign busy_rd = (rspeed != 8'd0) || (rlevel != 8'd0);

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        cand_k_next = cand_k_reg;
        nb_next = nb_reg;
        active_next = active_reg;
        nout_next = nout_reg;
        spawned_next = spawned_reg;
        scell_next = scell_reg;
        out_valid_next = out_valid_reg;
        kind_next = kind_reg;
        last_next = last_reg;
        ocell_next = ocell_reg;
        olevel_next = olevel_reg;
        nb_pending_next = nb_pending_reg;
        req.we = 1'b0;
        req.waddr = cur;
        req.wspeed = 8'd0;
        req.wlevel = 8'd0;
        req.raddr = cur;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                req.we = 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == (CW+1)'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                idx_next = '0;
                active_next = '0;
                nout_next = '0;
                spawned_next = 1'b0;
                scell_next = '0;
                cand_k_next = '0;
                if (in_valid)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (rspeed != 8'd0)
                begin
                    active_next = active_reg + 1'b1;
                    req.we = 1'b1;
                    req.wspeed = rspeed;
                    req.wlevel = sum[7:0];
                    if (!rspeed[7] && sum >= signed'(10'(max_level_reg)))
                    begin
                        req.wlevel = max_level_reg;
                        req.wspeed = 8'(-rspeed);
                    end
                    else if (rspeed[7] && sum <= 10'sd0)
                    begin
                        req.wlevel = 8'd0;
                        req.wspeed = 8'd0;
                    end
                    if (nout_reg < 4'(MAX_LIVE))
                    begin
                        nout_next = nout_reg + 1'b1;
                        ocell_next = cur;
                        olevel_next = req.wlevel;
                        kind_next = 1'b0;
                        last_next = 1'b0;
                        out_valid_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
                if (state_next != S_OUT)
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_RD;
                    if (idx_reg == (CW+1)'(CELLS - 1))
                    begin
                        state_next = S_CAND;
                        if (!(active_next < limit && roll_reg < spawn_percent_reg))
                        begin
                            cand_k_next = 4'd8;
                        end
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    if (last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_RD;
                        if (idx_reg == (CW+1)'(CELLS - 1))
                        begin
                            state_next = S_CAND;
                            if (!(active_reg < limit && roll_reg < spawn_percent_reg))
                            begin
                                cand_k_next = 4'd8;
                            end
                        end
                    end
                end
            end
            S_CAND:
            begin
                if (cand_k_reg == 4'd8)
                begin
                    kind_next = 1'b1;
                    last_next = 1'b1;
                    ocell_next = '0;
                    olevel_next = '0;
                    out_valid_next = 1'b1;
                    state_next = S_OUT;
                end
                else if (!cand_ok)
                begin
                    cand_k_next = cand_k_reg + 1'b1;
                end
                else
                begin
                    nb_next = 4'd4;
                    nb_pending_next = 1'b0;
                    state_next = S_NB;
                end
            end
            S_NB:
            begin
                // Issue read of neighbor nb_reg, check previous read result.
                req.raddr = CW'(nr) * CW'(COLS) + CW'(nc);
                if (nb_pending_reg && busy_rd)
                begin
                    cand_k_next = cand_k_reg + 1'b1;
                    state_next = S_CAND;
                end
                else if (nb_reg == 4'd9)
                begin
                    req.we = 1'b1;
                    req.waddr = cand_cur[CW-1:0];
                    req.wspeed = (spd == 7'd0) ? 8'd1 : {1'b0, spd};
                    req.wlevel = 8'd0;
                    spawned_next = 1'b1;
                    scell_next = cand_cur[CW-1:0];
                    cand_k_next = 4'd8;
                    state_next = S_CAND;
                end
                else
                begin
                    nb_pending_next = nb_in;
                    nb_next = (nb_reg == 4'd8) ? 4'd9 : ((nb_reg == 4'd4) ? 4'd0
                              : ((nb_reg == 4'd3) ? 4'd5 : nb_reg + 1'b1));
                    if (nb_reg == 4'd8 && !nb_in)
                    begin
                        nb_pending_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            cand_k_reg <= '0;
            nb_reg <= '0;
            active_reg <= '0;
            nout_reg <= '0;
            spawned_reg <= 1'b0;
            scell_reg <= '0;
            out_valid_reg <= 1'b0;
            last_reg <= 1'b0;
            kind_reg <= 1'b0;
            nb_pending_reg <= 1'b0;
            max_level_reg <= 8'd255;
            spawn_percent_reg <= 7'd20;
            speed_low_reg <= 7'd4;
            speed_high_reg <= 7'd16;
            live_limit_reg <= 4'd8;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            cand_k_reg <= cand_k_next;
            nb_reg <= nb_next;
            active_reg <= active_next;
            nout_reg <= nout_next;
            spawned_reg <= spawned_next;
            scell_reg <= scell_next;
            out_valid_reg <= out_valid_next;
            last_reg <= last_next;
            kind_reg <= kind_next;
            nb_pending_reg <= nb_pending_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_LEVEL:     max_level_reg <= cfg_data;
                    REG_SPAWN_PERCENT: spawn_percent_reg <= cfg_data[6:0];
                    REG_SPEED_LOW:     speed_low_reg <= cfg_data[6:0];
                    REG_SPEED_HIGH:    speed_high_reg <= cfg_data[6:0];
                    REG_LIVE_LIMIT:    live_limit_reg <= cfg_data[3:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ocell_reg <= ocell_next;
        olevel_reg <= olevel_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            roll_reg <= spawn_roll;
            off_reg <= speed_offset;
            cand_reg[0] <= cand_0;
            cand_reg[1] <= cand_1;
            cand_reg[2] <= cand_2;
            cand_reg[3] <= cand_3;
            cand_reg[4] <= cand_4;
            cand_reg[5] <= cand_5;
            cand_reg[6] <= cand_6;
            cand_reg[7] <= cand_7;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign is_last     = last_reg;
    assign pixel_col   = kind_reg ? 4'd0 : ocell_reg[COLW-1:0];
    assign pixel_row   = kind_reg ? 3'd0 : ocell_reg[CW-1:COLW];
    assign pixel_level = olevel_reg;
    assign spawned     = kind_reg & spawned_reg;
    assign spawn_cell  = kind_reg ? scell_reg : 7'd0;
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the sparkle animator: queued item driver, result monitor and tick predictor.
module tb_top;
    import lmsa_pkg::*;

    typedef struct {
        logic [6:0] roll;
        logic [6:0] offset;
        logic [6:0] cand [NCAND];
    } tick_t;

    typedef struct {
        logic       kind;
        logic [3:0] col;
        logic [2:0] row;
        logic [7:0] level;
        logic       spawned;
        logic [6:0] scell;
        logic       last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [6:0] spawn_roll = '0, speed_offset = '0;
    logic [6:0] cand_0 = '0, cand_1 = '0, cand_2 = '0, cand_3 = '0;
    logic [6:0] cand_4 = '0, cand_5 = '0, cand_6 = '0, cand_7 = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic kind, spawned, is_last;
    logic [3:0] pixel_col;
    logic [2:0] pixel_row;
    logic [7:0] pixel_level;
    logic [6:0] spawn_cell;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    tick_t  tick_queue[$];
    pixel_t expected_pixels[$];
    int mismatches = 0;
    int results_seen = 0;
    int ticks_sent = 0;
    int spawns_seen = 0;
    int cycles = 0;
    int send_gap = 0;
    int stall_gap = 0;
    bit hold_sender = 1'b0;
    bit in_taken = 1'b0;

    logic signed [7:0] speed_mem [CELLS];
    logic [7:0] level_mem [CELLS];
    int max_lvl, pct, spd_lo, spd_hi, lim;

    led_matrix_sparkle_animator_top DUT (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic bit cell_taken(int c);
        return speed_mem[c] != 0 || level_mem[c] != 0;
    endfunction

    function automatic bit lonely(int c);
        int r, k, nr, nk;
        r = c / COLS;
        k = c % COLS;
        for (int dr = -1; dr <= 1; dr++)
            for (int dk = -1; dk <= 1; dk++)
            begin
                nr = r + dr;
                nk = k + dk;
                if ((dr == 0 && dk == 0) || nr < 0 || nr >= ROWS || nk < 0 || nk >= COLS)
                    continue;
                if (cell_taken(nr * COLS + nk))
                    return 0;
            end
        return 1;
    endfunction

    task automatic advance_tick(input tick_t t);
        int active, n, b, sp, s, c, use_lim;
        pixel_t p;
        bit done;
        active = 0;
        n = 0;
        done = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            sp = speed_mem[i];
            if (sp == 0)
                continue;
            active++;
            b = level_mem[i] + sp;
            if (sp > 0 && b >= max_lvl)
            begin
                b = max_lvl;
                speed_mem[i] = 8'(-sp);
            end
            else if (sp < 0 && b <= 0)
            begin
                b = 0;
                speed_mem[i] = '0;
            end
            level_mem[i] = b[7:0];
            if (n < MAX_LIVE)
            begin
                p = '{1'b0, 4'(i % COLS), 3'(i / COLS), b[7:0], 1'b0, 7'd0, 1'b0};
                expected_pixels.push_back(p);
                n++;
            end
        end
        use_lim = lim < MAX_LIVE ? lim : MAX_LIVE;
        p = '{1'b1, 4'd0, 3'd0, 8'd0, 1'b0, 7'd0, 1'b1};
        if (active < use_lim && t.roll < pct)
            for (int k = 0; k < NCAND && !done; k++)
            begin
                c = t.cand[k];
                if (c >= CELLS)
                    continue;
                if (!cell_taken(c) && lonely(c))
                begin
                    s = spd_lo + t.offset;
                    if (s > spd_hi)
                        s = spd_hi;
                    if (s == 0)
                        s = 1;
                    speed_mem[c] = 8'(s);
                    level_mem[c] = '0;
                    p.spawned = 1'b1;
                    p.scell = 7'(c);
                    done = 1;
                end
            end
        expected_pixels.push_back(p);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 8'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MAX_LEVEL:     max_lvl = val;
            REG_SPAWN_PERCENT: pct = val;
            REG_SPEED_LOW:     spd_lo = val;
            REG_SPEED_HIGH:    spd_hi = val;
            default:           lim = val;
        endcase
    endtask

    task automatic queue_tick(input int roll, input int offset, input bit wild);
        tick_t t;
        t.roll = 7'(roll);
        t.offset = 7'(offset);
        foreach (t.cand[k])
            t.cand[k] = 7'(wild ? $urandom_range(0, 127) : $urandom_range(0, CELLS - 1));
        tick_queue.push_back(t);
    endtask

    task automatic drain();
        while (tick_queue.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        in_taken <= in_valid && !in_stall;
    end

    // driver
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (send_gap > 0 || hold_sender || tick_queue.size() == 0 || !rst_n)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                tick_t t;
                t = tick_queue.pop_front();
                advance_tick(t);
                ticks_sent <= ticks_sent + 1;
                in_valid <= 1'b1;
                spawn_roll <= t.roll;
                speed_offset <= t.offset;
                cand_0 <= t.cand[0];
                cand_1 <= t.cand[1];
                cand_2 <= t.cand[2];
                cand_3 <= t.cand[3];
                cand_4 <= t.cand[4];
                cand_5 <= t.cand[5];
                cand_6 <= t.cand[6];
                cand_7 <= t.cand[7];
                send_gap <= pick_gap();
            end
        end
        if (stall_gap > 0)
        begin
            out_stall <= 1'b1;
            stall_gap <= stall_gap - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            pixel_t e;
            results_seen <= results_seen + 1;
            if (expected_pixels.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result kind=%0d col=%0d row=%0d", kind, pixel_col,
                             pixel_row);
            end
            else
            begin
                e = expected_pixels.pop_front();
                if (kind && spawned)
                    spawns_seen <= spawns_seen + 1;
                if (kind !== e.kind || pixel_col !== e.col || pixel_row !== e.row ||
                    pixel_level !== e.level || spawned !== e.spawned ||
                    spawn_cell !== e.scell || is_last !== e.last)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display(
                            "mismatch exp k%0d c%0d r%0d l%0d s%0d x%0d e%0d",
                            e.kind, e.col, e.row, e.level, e.spawned, e.scell, e.last,
                            " got k%0d c%0d r%0d l%0d s%0d x%0d e%0d",
                            kind, pixel_col, pixel_row, pixel_level, spawned,
                            spawn_cell, is_last);
                end
            end
        end
    end

    initial
    begin
        foreach (speed_mem[i])
        begin
            speed_mem[i] = '0;
            level_mem[i] = '0;
        end
        max_lvl = 255;
        pct = 20;
        spd_lo = 4;
        spd_hi = 16;
        lim = 8;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        write_reg(REG_SPAWN_PERCENT, 100);
        write_reg(REG_MAX_LEVEL, 40);
        write_reg(REG_SPEED_LOW, 127);
        write_reg(REG_SPEED_HIGH, 127);
        write_reg(REG_LIVE_LIMIT, 15);
        queue_tick(0, 0, 1'b0);
        queue_tick(99, 126, 1'b0);
        drain();
        write_reg(REG_SPEED_LOW, 1);
        write_reg(REG_SPEED_HIGH, 20);
        write_reg(REG_MAX_LEVEL, 255);
        for (int j = 0; j < 12; j++)
        begin
            tick_t t;
            t.roll = 7'(j % 2 ? 99 : 0);
            t.offset = 7'(j * 11);
            foreach (t.cand[k])
                t.cand[k] = 7'((j + k) % 3 == 0 ? 127 - k : (j * 37 + k * 17) % 128);
            if (j == 3)
            begin
                t.cand[0] = 7'd0;
                t.cand[1] = 7'd127;
                t.cand[2] = 7'd1;
                t.cand[3] = 7'd15;
                t.cand[4] = 7'd112;
            end
            tick_queue.push_back(t);
        end
        drain();
        hold_sender = 1'b1;
        write_reg(REG_MAX_LEVEL, 0);
        write_reg(REG_LIVE_LIMIT, 0);
        hold_sender = 1'b0;
        queue_tick(0, 5, 1'b1);
        drain();
        write_reg(REG_LIVE_LIMIT, 8);
        queue_tick(0, 5, 1'b1);
        queue_tick(0, 5, 1'b1);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_MAX_LEVEL, ph == 0 ? 1 : $urandom_range(20, 255));
            write_reg(REG_SPAWN_PERCENT, ph == 3 ? 0 : $urandom_range(30, 100));
            write_reg(REG_SPEED_LOW, $urandom_range(1, 40));
            write_reg(REG_SPEED_HIGH, $urandom_range(1, 127));
            write_reg(REG_LIVE_LIMIT, $urandom_range(0, 15));
            for (int j = 0; j < 45; j++)
            begin
                queue_tick($urandom_range(0, 99), $urandom_range(0, 126),
                           $urandom_range(0, 4) == 0);
                if (j == 20)
                begin
                    while (tick_queue.size() != 0)
                        @(negedge clk);
                    hold_sender = 1'b1;
                    while (in_valid || expected_pixels.size() != 0)
                        @(negedge clk);
                    hold_sender = 1'b0;
                end
            end
            drain();
        end
        $display("Sent %0d ticks, checked %0d results, %0d spawns across several settings.",
                 ticks_sent, results_seen, spawns_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
